[sv/mscc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mscc_pkg;

	localparam int INPUT_SHIFT_DEF   = 13;
	localparam int TANH_DEPTH_DEF    = 256;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int KNEE_LEVEL = 26000;
	localparam int KNEE_RANGE = 6767;
	localparam int KNEE_SPAN  = 4 * KNEE_RANGE;

	localparam logic [15:0] DC_ALPHA_RST  = 16'd65208;
	localparam logic [15:0] LPF_ALPHA_RST = 16'd32768;
	localparam logic [15:0] ENV_SMOOTH_RST = 16'd62259;
	localparam logic [17:0] GATE_THR_RST  = 18'd100;
	localparam logic [15:0] GAIN_BOOST_RST = 16'd256;
	localparam logic [31:0] GATE_SLOPE_RST = 32'd874;

	typedef enum logic [2:0] {
		CFG_DC_ALPHA   = 3'd0,
		CFG_LPF_ALPHA  = 3'd1,
		CFG_ENV_SMOOTH = 3'd2,
		CFG_GATE_THR   = 3'd3,
		CFG_GAIN_BOOST = 3'd4,
		CFG_GATE_SLOPE = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_DC,
		OP_Y,
		OP_MUL_LP,
		OP_LP,
		OP_MUL_ENV,
		OP_ENV,
		OP_GATE,
		OP_MUL_SLOPE,
		OP_RAMP,
		OP_MUL_B,
		OP_ABS,
		OP_CHK,
		OP_MUL_IDX,
		OP_DIV_LD,
		OP_DIV,
		OP_MUL_TAB,
		OP_TAB,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic gate_mid;
		logic knee;
		logic over_big;
	} stat_t;

	// shift-subtract divide, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] rem;
		int b;
		q = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem = rem - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(65536*tanh(4*i/depth)) via exp(-8/depth) series in Q31
	function automatic logic [15:0] tanh_entry(input int depth, input int i);
		logic [63:0] one;
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] t;
		int k;
		int j;
		one = 64'd1 << 31;
		a = udiv64(64'd8 << 31, 64'(depth));
		term = one;
		r = one;
		p = one;
		for (k = 1; k <= 12; k++) begin
			term = udiv64((term * a) >> 31, 64'(k));
			if (k % 2 == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (j = 0; j < i; j++) begin
			p = (p * r) >> 31;
		end
		den = one + p;
		t = udiv64(((one - p) << 16) + (den >> 1), den);
		if (t > 64'd65535) begin
			t = 64'd65535;
		end
		return t[15:0];
	endfunction

endpackage

`default_nettype wire

[sv/mscc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module mscc_datapath
	import mscc_pkg::*;
#(
	parameter int INPUT_SHIFT      = INPUT_SHIFT_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
	parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [31:0] in_data,
	output logic [15:0]      pcm_sample,
	output logic [17:0]      envelope_level
);

	localparam int FS = FRACTION_BITS + 8;
	localparam int QW = $clog2(TANH_TABLE_DEPTH);
	localparam int OW = 15 + FS;
	localparam int AW = (OW + 1 > 34) ? OW + 1 : 34;
	localparam int BW = 34;
	localparam int PW = AW + BW;
	localparam int MW = 48;
	localparam int NW = OW + QW;
	localparam int NQ = QW + 15;
	localparam int RS = NQ + 15;
	localparam int TW = 18 + FRACTION_BITS;
	localparam int XW = 32 + FRACTION_BITS;

	localparam logic [MW-1:0] KNEE_M   = MW'(KNEE_LEVEL) << FS;
	localparam logic [MW-1:0] SPAN_M   = MW'(KNEE_SPAN) << FS;
	localparam logic [QW-1:0] IDX_LAST = QW'(TANH_TABLE_DEPTH - 1);
	// ceil(2^RS / span): exact quotient for any scaled offset below depth*span
	localparam logic [BW-1:0] RECIP    =
		BW'(((64'd1 << RS) + 64'(KNEE_SPAN) - 64'd1) / 64'(KNEE_SPAN));

	logic [15:0] dc_alpha_q, lpf_alpha_q, env_smooth_q, gain_boost_q;
	logic [17:0] gate_thr_q;
	logic [31:0] gate_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_alpha_q   <= DC_ALPHA_RST;
			lpf_alpha_q  <= LPF_ALPHA_RST;
			env_smooth_q <= ENV_SMOOTH_RST;
			gate_thr_q   <= GATE_THR_RST;
			gain_boost_q <= GAIN_BOOST_RST;
			gate_slope_q <= GATE_SLOPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DC_ALPHA:   dc_alpha_q   <= cfg_data[15:0];
				CFG_LPF_ALPHA:  lpf_alpha_q  <= cfg_data[15:0];
				CFG_ENV_SMOOTH: env_smooth_q <= cfg_data[15:0];
				CFG_GATE_THR:   gate_thr_q   <= cfg_data[17:0];
				CFG_GAIN_BOOST: gain_boost_q <= cfg_data[15:0];
				CFG_GATE_SLOPE: gate_slope_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [15:0] tab [TANH_TABLE_DEPTH];
	for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [15:0] V = tanh_entry(TANH_TABLE_DEPTH, g);
		assign tab[g] = V;
	end

	logic signed [31:0] x_q, dpi_q, dpo_q, lp_q;
	logic [31:0]        env_q;
	logic [15:0]        gain_q, mag_q;
	logic               neg_q;
	logic [MW-1:0]      m_q;
	logic [QW-1:0]      idx_q;
	logic signed [PW-1:0] prod_q;
	logic [15:0]        pcm_q;
	logic [17:0]        envl_q;

	logic signed [31:0] sh;
	logic signed [XW-1:0] xw;
	logic signed [31:0] x_sat;
	logic signed [33:0] ysum;
	logic signed [31:0] y_sat;
	logic signed [32:0] d_lp;
	logic signed [34:0] lsum;
	logic signed [31:0] lp_sat;
	logic [31:0]        absx;
	logic signed [32:0] d_env;
	logic [33:0]        esum;
	logic [TW-1:0]      thr, qtr;
	logic               env_ge, env_le;
	logic [63-FS:0]     ramp;
	logic [MW-1:0]      bmag, over;
	logic [31:0]        env_int;
	logic signed [AW-1:0] ma;
	logic signed [BW-1:0] mb;
	logic               mul_en;

	always_comb begin
		sh = $signed(in_data) >>> INPUT_SHIFT;
		xw = XW'(sh) <<< FRACTION_BITS;
		if ((xw[XW-1:31] == '0) || (xw[XW-1:31] == '1)) begin
			x_sat = xw[31:0];
		end else begin
			x_sat = xw[XW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end

		ysum = 34'(x_q) - 34'(dpi_q) + 34'($signed(prod_q[47:16]));
		if ((ysum[33:31] == '0) || (ysum[33:31] == '1)) begin
			y_sat = ysum[31:0];
		end else begin
			y_sat = ysum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end

		d_lp = 33'(dpo_q) - 33'(lp_q);
		lsum = 35'(lp_q) + 35'($signed(prod_q[49:16]));
		if ((lsum[34:31] == '0) || (lsum[34:31] == '1)) begin
			lp_sat = lsum[31:0];
		end else begin
			lp_sat = lsum[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end

		absx = lp_q[31] ? 32'(-lp_q) : 32'(lp_q);
		d_env = $signed({1'b0, env_q}) - $signed({1'b0, absx});
		esum = {2'b00, absx} + prod_q[49:16];

		thr = {gate_thr_q, {FRACTION_BITS{1'b0}}};
		qtr = thr >> 2;
		env_ge = env_q >= 32'(thr);
		env_le = env_q <= 32'(qtr);
		ramp = prod_q[63:FS];

		bmag = prod_q[PW-1] ? MW'(-prod_q[MW-1:0]) : prod_q[MW-1:0];
		over = m_q - KNEE_M;
		env_int = env_q >> FRACTION_BITS;

		stat.gate_mid = !env_ge && !env_le;
		stat.knee = m_q > KNEE_M;
		stat.over_big = over >= SPAN_M;

		mul_en = 1'b1;
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_DC: begin
				ma = AW'(dpo_q);
				mb = BW'(dc_alpha_q);
			end
			OP_MUL_LP: begin
				ma = AW'(d_lp);
				mb = BW'(lpf_alpha_q);
			end
			OP_MUL_ENV: begin
				ma = AW'(d_env);
				mb = BW'(env_smooth_q);
			end
			OP_MUL_SLOPE: begin
				ma = AW'(env_q - 32'(qtr));
				mb = BW'(gate_slope_q);
			end
			OP_MUL_B: begin
				ma = AW'(lp_q);
				mb = BW'(gain_q);
			end
			OP_MUL_IDX: begin
				ma = AW'(over[OW-1:0]);
				mb = BW'(TANH_TABLE_DEPTH);
			end
			OP_DIV_LD: begin
				ma = AW'(prod_q[NW-1:FS]);
				mb = RECIP;
			end
			OP_MUL_TAB: begin
				ma = AW'(tab[idx_q]);
				mb = BW'(KNEE_RANGE);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			x_q <= '0;
			dpi_q <= '0;
			dpo_q <= '0;
			lp_q <= '0;
			env_q <= '0;
			gain_q <= '0;
			neg_q <= 1'b0;
			m_q <= '0;
			idx_q <= '0;
			mag_q <= '0;
			pcm_q <= '0;
			envl_q <= '0;
		end else begin
			if (mul_en) begin
				prod_q <= ma * mb;
			end
			case (cmd.op)
				OP_LOAD: x_q <= x_sat;
				OP_Y: begin
					dpo_q <= y_sat;
					dpi_q <= x_q;
				end
				OP_LP:  lp_q <= lp_sat;
				OP_ENV: env_q <= esum[31:0];
				OP_GATE: gain_q <= env_ge ? gain_boost_q : 16'd0;
				OP_RAMP: gain_q <= (ramp > (64 - FS)'(gain_boost_q)) ? gain_boost_q
					: ramp[15:0];
				OP_ABS: begin
					neg_q <= prod_q[PW-1];
					m_q <= bmag;
				end
				OP_CHK: begin
					idx_q <= IDX_LAST;
					mag_q <= 16'(m_q >> FS);
				end
				OP_DIV: idx_q <= prod_q[RS+QW-1:RS];
				OP_TAB: mag_q <= 16'(KNEE_LEVEL) + prod_q[31:16];
				OP_OUT: begin
					pcm_q <= neg_q ? 16'(-mag_q) : mag_q;
					envl_q <= (env_int[31:18] != '0) ? 18'h3ffff : env_int[17:0];
				end
				default: ;
			endcase
		end
	end

	assign pcm_sample = pcm_q;
	assign envelope_level = envl_q;

endmodule

`default_nettype wire

[sv/mscc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mscc_ctrl
	import mscc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [18:0] {
		S_IDLE = 19'd1 << 0,
		S_MDC  = 19'd1 << 1,
		S_Y    = 19'd1 << 2,
		S_MLP  = 19'd1 << 3,
		S_LP   = 19'd1 << 4,
		S_MENV = 19'd1 << 5,
		S_ENV  = 19'd1 << 6,
		S_GATE = 19'd1 << 7,
		S_MSLP = 19'd1 << 8,
		S_RAMP = 19'd1 << 9,
		S_MB   = 19'd1 << 10,
		S_ABS  = 19'd1 << 11,
		S_CHK  = 19'd1 << 12,
		S_MIDX = 19'd1 << 13,
		S_DLD  = 19'd1 << 14,
		S_DIV  = 19'd1 << 15,
		S_MTAB = 19'd1 << 16,
		S_TAB  = 19'd1 << 17,
		S_OUT  = 19'd1 << 18
	} state_t;

	state_t state_q, state_d;
	logic ov_q;
	logic load;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		load = 1'b0;
		case (state_q)
			S_IDLE: if (s_tvalid) begin
				cmd.op = OP_LOAD;
				state_d = S_MDC;
			end
			S_MDC: begin
				cmd.op = OP_MUL_DC;
				state_d = S_Y;
			end
			S_Y: begin
				cmd.op = OP_Y;
				state_d = S_MLP;
			end
			S_MLP: begin
				cmd.op = OP_MUL_LP;
				state_d = S_LP;
			end
			S_LP: begin
				cmd.op = OP_LP;
				state_d = S_MENV;
			end
			S_MENV: begin
				cmd.op = OP_MUL_ENV;
				state_d = S_ENV;
			end
			S_ENV: begin
				cmd.op = OP_ENV;
				state_d = S_GATE;
			end
			S_GATE: begin
				cmd.op = OP_GATE;
				state_d = stat.gate_mid ? S_MSLP : S_MB;
			end
			S_MSLP: begin
				cmd.op = OP_MUL_SLOPE;
				state_d = S_RAMP;
			end
			S_RAMP: begin
				cmd.op = OP_RAMP;
				state_d = S_MB;
			end
			S_MB: begin
				cmd.op = OP_MUL_B;
				state_d = S_ABS;
			end
			S_ABS: begin
				cmd.op = OP_ABS;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.op = OP_CHK;
				if (!stat.knee) begin
					state_d = S_OUT;
				end else if (stat.over_big) begin
					state_d = S_MTAB;
				end else begin
					state_d = S_MIDX;
				end
			end
			S_MIDX: begin
				cmd.op = OP_MUL_IDX;
				state_d = S_DLD;
			end
			S_DLD: begin
				cmd.op = OP_DIV_LD;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				state_d = S_MTAB;
			end
			S_MTAB: begin
				cmd.op = OP_MUL_TAB;
				state_d = S_TAB;
			end
			S_TAB: begin
				cmd.op = OP_TAB;
				state_d = S_OUT;
			end
			S_OUT: if (!ov_q || m_tready) begin
				cmd.op = OP_OUT;
				load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;

endmodule

`default_nettype wire

[sv/mic_sample_conditioning_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

// Conditions one 32-bit microphone word per beat into a 16-bit PCM sample plus
// the 18-bit envelope level: input shift, DC blocker, one-pole low-pass,
// envelope follower, noise gate and tanh soft knee. One beat is taken at a
// time; the gate ramp steps run only between the quarter threshold and the
// threshold, the knee steps only past the knee, and the index steps only
// for a knee inside the table. Input is taken again in the cycle after the
// result is loaded. The steps share a single multiplier; the table index
// comes from a reciprocal multiply. A finished result waits in the output
// register while the next beat runs; that beat stalls at its last step
// until the waiting result is taken. Configuration is written on cfg_we; the
// user must write it only while no beat is in flight; the block has no check.
module mic_sample_conditioning_chain
	import mscc_pkg::*;
#(
	parameter int INPUT_SHIFT      = INPUT_SHIFT_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
	parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] raw_sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // [15:0] pcm_sample, [33:16] envelope_level
);

	cmd_t  cmd;
	stat_t stat;
	logic [15:0] pcm;
	logic [17:0] envl;

	mscc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat(stat),
		.cmd(cmd)
	);

	mscc_datapath #(
		.INPUT_SHIFT(INPUT_SHIFT),
		.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat),
		.in_data(s_tdata),
		.pcm_sample(pcm),
		.envelope_level(envl)
	);

	assign m_tdata = {6'b0, envl, pcm};

endmodule

`default_nettype wire

[sv/mscc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mscc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a beat");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("output pad bits not zero");

endmodule

bind mic_sample_conditioning_chain mscc_checker u_mscc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

`default_nettype wire

[test/mic_sample_conditioning_chain_test.sv]
`timescale 1ns / 1ps

module mic_sample_conditioning_chain_test;
	import mscc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 64;

	typedef struct packed {
		logic signed [15:0] pcm;
		logic [17:0]        env_level;
	} cond_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	mic_sample_conditioning_chain dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of registers and filter state
	logic [15:0] p_dc_alpha, p_lpf_alpha, p_env_smooth, p_gain_boost;
	logic [17:0] p_gate_thr;
	logic [31:0] p_gate_slope;
	longint      p_dc_in, p_dc_out, p_lp;
	longint      p_env;
	logic [15:0] tanh_lut [TANH_DEPTH_DEF];

	logic [31:0] raw_queue [$];
	cond_out_t   cond_expected [$];
	int          failures = 0;
	bit          quiet = 1'b0;
	bit          hold_sender = 1'b0;
	int          watchdog = 0;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic predict_sample(input logic [31:0] raw);
		longint x, y, lp, absv, thr, qtr, gain, b, m, over, idx, mag;
		cond_out_t r;
		x = sat32(floor_sh(longint'($signed(raw)), INPUT_SHIFT_DEF) <<< FRACTION_BITS_DEF);
		y = sat32(x - p_dc_in + floor_sh(longint'(p_dc_alpha) * p_dc_out, 16));
		p_dc_in = x;
		p_dc_out = y;
		lp = sat32(floor_sh(p_lp * (65536 - longint'(p_lpf_alpha))
			+ y * longint'(p_lpf_alpha), 16));
		p_lp = lp;
		absv = lp < 0 ? -lp : lp;
		p_env = (p_env * longint'(p_env_smooth) + absv * (65536 - longint'(p_env_smooth)))
			>> 16;
		p_env = p_env & 64'hFFFF_FFFF;
		thr = longint'(p_gate_thr) << FRACTION_BITS_DEF;
		qtr = thr >> 2;
		if (p_env >= thr) gain = p_gate_boost_l();
		else if (p_env <= qtr) gain = 0;
		else begin
			gain = longint'(64'((p_env - qtr) * longint'(p_gate_slope)) >> 16);
			if (gain > longint'(p_gain_boost)) gain = p_gain_boost;
		end
		b = lp * gain;
		m = b < 0 ? -b : b;
		if (m > (longint'(KNEE_LEVEL) << 16)) begin
			over = m - (longint'(KNEE_LEVEL) << 16);
			idx = longint'(64'(over * TANH_DEPTH_DEF) / (64'(KNEE_SPAN) << 16));
			if (idx >= TANH_DEPTH_DEF) idx = TANH_DEPTH_DEF - 1;
			mag = KNEE_LEVEL + ((longint'(KNEE_RANGE) * tanh_lut[idx]) >> 16);
		end else begin
			mag = m >> 16;
		end
		r.pcm = b < 0 ? 16'(-mag) : 16'(mag);
		r.env_level = (p_env >> FRACTION_BITS_DEF) > 262143 ? 18'h3FFFF
			: 18'(p_env >> FRACTION_BITS_DEF);
		cond_expected.push_back(r);
	endtask

	function automatic longint p_gate_boost_l();
		return longint'(p_gain_boost);
	endfunction

	// tanh table, built the same way the hardware fixes it: Q31 exp series
	task automatic build_tanh();
		logic [63:0] one, a, term, r, p, den, t;
		one = 64'd1 << 31;
		a = (64'd8 << 31) / TANH_DEPTH_DEF;
		term = one;
		r = one;
		p = one;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * a) >> 31) / k;
			if (k % 2 == 1) r = r - term;
			else r = r + term;
		end
		for (int i = 0; i < TANH_DEPTH_DEF; i++) begin
			den = one + p;
			t = (((one - p) << 16) + den / 2) / den;
			tanh_lut[i] = t > 65535 ? 16'hFFFF : t[15:0];
			p = (p * r) >> 31;
		end
	endtask

	task automatic reset_model();
		p_dc_alpha = DC_ALPHA_RST;
		p_lpf_alpha = LPF_ALPHA_RST;
		p_env_smooth = ENV_SMOOTH_RST;
		p_gate_thr = GATE_THR_RST;
		p_gain_boost = GAIN_BOOST_RST;
		p_gate_slope = GATE_SLOPE_RST;
		p_dc_in = 0;
		p_dc_out = 0;
		p_lp = 0;
		p_env = 0;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DC_ALPHA:   p_dc_alpha = val[15:0];
			CFG_LPF_ALPHA:  p_lpf_alpha = val[15:0];
			CFG_ENV_SMOOTH: p_env_smooth = val[15:0];
			CFG_GATE_THR:   p_gate_thr = val[17:0];
			CFG_GAIN_BOOST: p_gain_boost = val[15:0];
			CFG_GATE_SLOPE: p_gate_slope = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (raw_queue.size() != 0 || s_tvalid || cond_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// noisy word with an occasional loud burst
	function automatic logic [31:0] rand_raw();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) return $urandom();
		if (sel < 4) return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 99999)
			: 32'h8000_0000 + $urandom_range(0, 99999);
		return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)) << $urandom_range(0, 6);
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_sample(s_tdata);
		end
		if (!s_tvalid || s_tready) begin
			if (raw_queue.size() != 0 && !hold_sender && (quiet || $urandom_range(0, 99) >= 36))
			begin
				s_tvalid <= 1'b1;
				s_tdata <= raw_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cond_out_t got, want;
		if (m_tvalid && m_tready) begin
			got = cond_out_t'({m_tdata[15:0], m_tdata[33:16]});
			if (cond_expected.size() == 0) begin
				$error("result with nothing expected: pcm=%0d env=%0d", got.pcm, got.env_level);
				failures++;
			end else begin
				want = cond_expected.pop_front();
				if (got.pcm !== want.pcm) begin
					$error("pcm_sample expected %0d actual %0d", want.pcm, got.pcm);
					failures++;
				end
				if (got.env_level !== want.env_level) begin
					$error("envelope_level expected %0d actual %0d", want.env_level,
						got.env_level);
					failures++;
				end
			end
		end
		m_tready <= quiet || $urandom_range(0, 99) >= 36;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		build_tanh();
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes at reset settings
		raw_queue.push_back(32'h7FFF_FFFF);
		raw_queue.push_back(32'h8000_0000);
		raw_queue.push_back(32'h0000_0000);
		raw_queue.push_back(32'hFFFF_FFFF);
		raw_queue.push_back(32'h7FFF_FFFF);
		raw_queue.push_back(32'h7FFF_FFFF);
		raw_queue.push_back(32'h0000_2000);
		raw_queue.push_back(32'h8000_0000);
		wait_idle();

		// high gain, fast filters: knee and table overrun
		write_reg(CFG_GAIN_BOOST, 32'hFFFF);
		write_reg(CFG_LPF_ALPHA, 32'hFFFF);
		write_reg(CFG_DC_ALPHA, 32'h0);
		write_reg(CFG_ENV_SMOOTH, 32'h0);
		write_reg(CFG_GATE_THR, 32'h0);
		write_reg(CFG_GATE_SLOPE, 32'hFFFF_FFFF);
		write_reg(cfg_idx_t'(3'd7), 32'h1234);
		for (int i = 0; i < 8; i++) raw_queue.push_back(i[0] ? 32'h0010_0000 : 32'hFFF0_0000);
		raw_queue.push_back(32'h7FFF_FFFF);
		raw_queue.push_back(32'h8000_0000);
		wait_idle();

		// ramp region with overshoot; extreme coefficients
		write_reg(CFG_GATE_THR, 32'h3FFFF);
		write_reg(CFG_GAIN_BOOST, 32'd300);
		write_reg(CFG_ENV_SMOOTH, 32'hFFFF);
		write_reg(CFG_DC_ALPHA, 32'hFFFF);
		write_reg(CFG_LPF_ALPHA, 32'h0);
		for (int i = 0; i < 5; i++) raw_queue.push_back(rand_raw());
		wait_idle();

		// random phases over assorted settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_DC_ALPHA, ph == 0 ? 32'd65208 : $urandom());
			write_reg(CFG_LPF_ALPHA, $urandom());
			write_reg(CFG_ENV_SMOOTH, ph[0] ? $urandom_range(0, 65535) : 32'hC000);
			write_reg(CFG_GATE_THR, ph[1] ? $urandom_range(0, 40000) : $urandom());
			write_reg(CFG_GAIN_BOOST, $urandom_range(0, 4) == 0 ? $urandom()
				: $urandom_range(0, 1024));
			write_reg(CFG_GATE_SLOPE, ph[2] ? $urandom() : $urandom_range(0, 200000));
			quiet = (ph == 3);
			for (int i = 0; i < 140; i++) begin
				raw_queue.push_back(rand_raw());
				if (ph == 5 && i == 70) begin
					while (raw_queue.size() != 0 || s_tvalid) @(posedge clk);
					hold_sender = 1'b1;
					while (cond_expected.size() != 0) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			wait_idle();
		end

		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
